// ----- sv/mexp_pkg.sv -----
// Shared widths and types for the modular exponentiation unit.
// No dependencies.
package mexp_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [WIDTH+1:0] ext_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t LAST_CNT = cnt_t'(WIDTH - 1);

endpackage

// ----- sv/modular_exponentiation_unit.sv -----
// Modular exponentiation unit: right-to-left square and multiply over a
// bit-serial modular multiplier. Depends on mexp_pkg.
//
//   channel   | ports                                     | handshake
//   ----------+-------------------------------------------+-------------------
//   request   | start, busy, base_value, exponent         | start & !busy
//   result    | done, power_result                        | done, one cycle
//   modulus   | modulus_valid, modulus_ready, modulus     | valid & ready
//
// One modular multiplication runs on the shared shift-add unit, one multiplier
// bit per cycle. A request reduces the base, squares once for each exponent
// bit but the last and multiplies once for each set exponent bit; done rises
// in the cycle after the last of these steps. Reset sets the modulus to 1 and
// idles the unit. The result cannot be stalled; modulus writes are taken while
// busy is low.
module modular_exponentiation_unit
  import mexp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  word_t base_value,
  input  word_t exponent,
  output logic  done,
  output word_t power_result,
  input  logic  modulus_valid,
  output logic  modulus_ready,
  input  word_t modulus
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REDUCE = 2'd1;
  localparam logic [1:0] ST_MUL    = 2'd2;
  localparam logic [1:0] ST_SQR    = 2'd3;

  logic [1:0] state, state_next;
  word_t      modulus_q;
  word_t      acc, acc_next;
  word_t      bb, bb_next;
  word_t      ee, ee_next;
  word_t      r, r_next;
  word_t      mshift, mshift_next;
  cnt_t       cnt, cnt_next;
  cnt_t       bitn, bitn_next;
  logic       done_next;
  word_t      result_next;

  ext_t  m_ext;
  ext_t  dbl, dbl_red, addend, sum, sum_red;
  word_t step_r;
  logic  mbit;
  logic  go;
  logic  finish;
  logic  to_mul;

  assign busy          = (state != ST_IDLE);
  assign modulus_ready = !busy;

  always_comb begin
    m_ext   = (modulus_q == '0) ? (ext_t'(1) << WIDTH) : ext_t'(modulus_q);
    mbit    = mshift[WIDTH-1];
    dbl     = {1'b0, r, 1'b0};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    if (state == ST_REDUCE) begin
      addend = ext_t'(mbit);
    end else begin
      addend = mbit ? ext_t'(bb) : '0;
    end
    sum     = dbl_red + addend;
    sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    step_r  = sum_red[WIDTH-1:0];
  end

  always_comb begin
    state_next  = state;
    acc_next    = acc;
    bb_next     = bb;
    ee_next     = ee;
    r_next      = r;
    mshift_next = mshift;
    cnt_next    = cnt;
    bitn_next   = bitn;
    done_next   = 1'b0;
    result_next = power_result;
    go          = 1'b0;
    finish      = 1'b0;
    to_mul      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          acc_next    = word_t'(1);
          ee_next     = exponent;
          bitn_next   = '0;
          mshift_next = base_value;
          r_next      = '0;
          cnt_next    = LAST_CNT;
          state_next  = ST_REDUCE;
        end
      end
      ST_REDUCE, ST_MUL, ST_SQR: begin
        mshift_next = mshift << 1;
        r_next      = step_r;
        cnt_next    = cnt - cnt_t'(1);
        if (cnt == '0) begin
          go       = 1'b1;
          r_next   = '0;
          cnt_next = LAST_CNT;
        end
      end
    endcase

    if (go) begin
      unique case (state)
        ST_MUL: begin
          acc_next = step_r;
          finish   = (bitn == LAST_CNT);
        end
        ST_SQR: begin
          bb_next   = step_r;
          ee_next   = ee >> 1;
          bitn_next = bitn + cnt_t'(1);
          to_mul    = ee_next[0];
          finish    = !ee_next[0] && (bitn_next == LAST_CNT);
        end
        default: begin
          bb_next = step_r;
          to_mul  = ee[0];
          finish  = !ee[0] && (bitn == LAST_CNT);
        end
      endcase
      priority if (finish) begin
        state_next  = ST_IDLE;
        done_next   = 1'b1;
        result_next = acc_next;
      end else if (to_mul) begin
        state_next  = ST_MUL;
        mshift_next = acc_next;
      end else begin
        state_next  = ST_SQR;
        mshift_next = bb_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      modulus_q <= word_t'(1);
      cnt       <= '0;
      bitn      <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      cnt   <= cnt_next;
      bitn  <= bitn_next;
      if (modulus_valid && modulus_ready) begin
        modulus_q <= modulus;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc          <= acc_next;
    bb           <= bb_next;
    ee           <= ee_next;
    r            <= r_next;
    mshift       <= mshift_next;
    power_result <= result_next;
  end

endmodule
